@@ rtl/led_blink_duty_controller_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LED_BLINK_DUTY_CONTROLLER_DEFINES_SVH
`define LED_BLINK_DUTY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LBDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbdc check failed");

// Next-cycle implication, disabled while reset is asserted
`define LBDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbdc check failed");

`endif

@@ rtl/lbdc_pkg.sv @@
`timescale 1ns / 1ps

package lbdc_pkg;

    // Field and register widths
    localparam int DUTY_BITS     = 13;
    localparam int INTERVAL_BITS = 16;
    localparam int IV_FIELD_BITS = 16;
    localparam int CNT_BITS      = 16;
    localparam int PCT_BITS      = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
    localparam logic [PCT_BITS-1:0]  PCT_MAX  = 7'd100;

    // Divide-by-100 by reciprocal: exact for any dividend below 2^PROD_BITS
    localparam int PROD_BITS  = DUTY_BITS + PCT_BITS;
    localparam int DIV_SHIFT  = PROD_BITS + 7;
    localparam int RECIP_BITS = PROD_BITS + 1;
    localparam logic [63:0] DIV100_RECIP_W = ((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100;
    localparam logic [RECIP_BITS-1:0] DIV100_RECIP = DIV100_RECIP_W[RECIP_BITS-1:0];

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ON_DUTY_PERCENT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_ACTIVE      = 2'd1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_OFF   = 2'd1,
        REQ_ON    = 2'd2,
        REQ_BLINK = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2
    } t_mode;

    typedef struct packed {
        t_req                      req;
        logic [IV_FIELD_BITS-1:0]  interval;
        logic [CNT_BITS-1:0]       count;
        logic                      unlimited;
    } t_item;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 low_active;
    } t_cfg;

endpackage

@@ rtl/lbdc_cfg.sv @@
`timescale 1ns / 1ps

module lbdc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lbdc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lbdc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output lbdc_pkg::t_cfg                      o_cfg
);

    logic [lbdc_pkg::PCT_BITS-1:0]                        w_pct;
    logic [lbdc_pkg::PROD_BITS-1:0]                       w_scaled;
    logic [lbdc_pkg::PROD_BITS+lbdc_pkg::RECIP_BITS-1:0]  w_prod;
    logic [lbdc_pkg::DUTY_BITS-1:0]                       w_duty;
    logic [lbdc_pkg::DUTY_BITS-1:0]                       r_duty;
    logic                                                 r_low_active;

    // Clamp percent, then duty = max*pct/100 with max*pct = (pct << bits) - pct
    assign w_pct    = (i_cfg_data[lbdc_pkg::PCT_BITS-1:0] > lbdc_pkg::PCT_MAX)
                    ? lbdc_pkg::PCT_MAX : i_cfg_data[lbdc_pkg::PCT_BITS-1:0];
    assign w_scaled = (lbdc_pkg::PROD_BITS'(w_pct) << lbdc_pkg::DUTY_BITS)
                    - lbdc_pkg::PROD_BITS'(w_pct);
    assign w_prod   = {{lbdc_pkg::RECIP_BITS{1'b0}}, w_scaled}
                    * {{lbdc_pkg::PROD_BITS{1'b0}}, lbdc_pkg::DIV100_RECIP};
    assign w_duty   = w_prod[lbdc_pkg::DIV_SHIFT +: lbdc_pkg::DUTY_BITS];

    // Register file; the lit duty is kept already scaled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty       <= lbdc_pkg::DUTY_MAX;
            r_low_active <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lbdc_pkg::CFG_ON_DUTY_PERCENT: r_duty       <= w_duty;
                lbdc_pkg::CFG_LOW_ACTIVE:      r_low_active <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.duty       = r_duty;
    assign o_cfg.low_active = r_low_active;

endmodule

@@ rtl/lbdc_in_reg.sv @@
`timescale 1ns / 1ps

module lbdc_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  lbdc_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_in_stall,
    output logic            o_item_valid,
    output lbdc_pkg::t_item o_item
);

    logic            r_valid;
    lbdc_pkg::t_item r_item;

    // Hold the registered transaction while the result stage cannot move
    assign o_in_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

@@ rtl/lbdc_core.sv @@
`timescale 1ns / 1ps

module lbdc_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_item_valid,
    input  lbdc_pkg::t_item                 i_item,
    input  lbdc_pkg::t_cfg                  i_cfg,
    input  logic                            i_out_stall,
    output logic                            o_advance,
    output logic                            o_out_valid,
    output logic                            o_drive_active,
    output logic [lbdc_pkg::DUTY_BITS-1:0]  o_duty_ticks,
    output logic                            o_idle_level,
    output logic [1:0]                      o_mode_now
);

    localparam int IVB = lbdc_pkg::INTERVAL_BITS;

    lbdc_pkg::t_mode                r_mode,      n_mode;
    logic                           r_level,     n_level;
    logic [IVB-1:0]                 r_interval,  n_interval;
    logic [lbdc_pkg::CNT_BITS-1:0]  r_remain,    n_remain;
    logic                           r_unlimited, n_unlimited;
    logic [IVB-1:0]                 r_elapsed,   n_elapsed;

    logic                           r_out_valid;
    logic                           r_out_active;
    logic [lbdc_pkg::DUTY_BITS-1:0] r_out_duty;
    logic                           r_out_idle;
    logic [1:0]                     r_out_mode;

    logic                           w_fire;
    logic                           w_step;
    logic                           w_active;
    logic [IVB:0]                   w_elapsed_inc;
    logic [31:0]                    w_iv_ext;
    logic [IVB-1:0]                 w_iv;
    logic [lbdc_pkg::DUTY_BITS-1:0] w_duty_lit;

    // Result stage moves when empty or drained this cycle
    assign o_advance = !r_out_valid || !i_out_stall;
    assign w_fire    = i_item_valid && o_advance;

    assign w_elapsed_inc = {1'b0, r_elapsed} + (IVB + 1)'(1);
    assign w_iv_ext      = {{(32 - lbdc_pkg::IV_FIELD_BITS){1'b0}}, i_item.interval};
    assign w_iv          = w_iv_ext[IVB-1:0];

    // Next state for one transaction
    always_comb begin
        n_mode      = r_mode;
        n_level     = r_level;
        n_interval  = r_interval;
        n_remain    = r_remain;
        n_unlimited = r_unlimited;
        n_elapsed   = r_elapsed;
        w_step      = 1'b0;

        case (i_item.req)
            lbdc_pkg::REQ_TICK: begin
                if (r_mode == lbdc_pkg::MODE_BLINK) begin
                    if (w_elapsed_inc >= {1'b0, r_interval}) begin
                        n_elapsed = '0;
                        w_step    = 1'b1;
                    end else begin
                        n_elapsed = w_elapsed_inc[IVB-1:0];
                    end
                end
            end
            lbdc_pkg::REQ_OFF: begin
                n_mode = lbdc_pkg::MODE_OFF;
            end
            lbdc_pkg::REQ_ON: begin
                n_mode = lbdc_pkg::MODE_ON;
            end
            default: begin
                n_interval  = (w_iv == '0) ? IVB'(1) : w_iv;
                n_remain    = i_item.count;
                n_unlimited = i_item.unlimited;
                if (r_mode != lbdc_pkg::MODE_BLINK) begin
                    n_level = 1'b0;
                end
                n_mode    = lbdc_pkg::MODE_BLINK;
                n_elapsed = '0;
                w_step    = 1'b1;
            end
        endcase

        // Blink step: finite count exhausted drops to off, else toggle
        if (w_step) begin
            if (!n_unlimited && n_remain == '0) begin
                n_mode = lbdc_pkg::MODE_OFF;
            end else begin
                n_level = !n_level;
                if (!n_level && !n_unlimited) begin
                    n_remain = n_remain - lbdc_pkg::CNT_BITS'(1);
                end
            end
        end
    end

    assign w_active   = (n_mode == lbdc_pkg::MODE_ON)
                     || (n_mode == lbdc_pkg::MODE_BLINK && n_level);
    assign w_duty_lit = i_cfg.low_active ? (lbdc_pkg::DUTY_MAX - i_cfg.duty) : i_cfg.duty;

    // Blink state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= lbdc_pkg::MODE_OFF;
            r_level     <= 1'b0;
            r_interval  <= IVB'(1);
            r_remain    <= '0;
            r_unlimited <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_mode      <= n_mode;
                r_level     <= n_level;
                r_interval  <= n_interval;
                r_remain    <= n_remain;
                r_unlimited <= n_unlimited;
                r_elapsed   <= n_elapsed;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_active <= w_active;
            r_out_duty   <= w_active ? w_duty_lit : '0;
            r_out_idle   <= i_cfg.low_active;
            r_out_mode   <= n_mode;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_active = r_out_active;
    assign o_duty_ticks   = r_out_duty;
    assign o_idle_level   = r_out_idle;
    assign o_mode_now     = r_out_mode;

endmodule

@@ rtl/led_blink_duty_controller.sv @@
`timescale 1ns / 1ps
// A result is offered once its accepted input transaction has passed the input
// register, then the state update into the result register. Throughput: one
// transaction per cycle unless stalled; the blink state updates in a single pass.
// Reset (synchronous, active low): mode off, unlit, interval 1, count 0,
// duty 100 percent, high-active LED; both stages empty.

module led_blink_duty_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [lbdc_pkg::IV_FIELD_BITS-1:0]  i_blink_interval_ms,
    input  logic [lbdc_pkg::CNT_BITS-1:0]       i_blink_count,
    input  logic                                i_blink_forever,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_drive_active,
    output logic [lbdc_pkg::DUTY_BITS-1:0]      o_duty_ticks,
    output logic                                o_idle_level,
    output logic [1:0]                          o_mode_now,
    input  logic                                i_cfg_we,
    input  logic [lbdc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lbdc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    lbdc_pkg::t_item w_in_item;
    lbdc_pkg::t_item w_item;
    lbdc_pkg::t_cfg  w_cfg;
    logic            w_item_valid;
    logic            w_advance;

    assign w_in_item.req       = lbdc_pkg::t_req'(i_req_type);
    assign w_in_item.interval  = i_blink_interval_ms;
    assign w_in_item.count     = i_blink_count;
    assign w_in_item.unlimited = i_blink_forever;

    // Configuration registers and lit duty
    lbdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Input register
    lbdc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_item       (w_in_item),
        .i_advance    (w_advance),
        .o_in_stall   (o_in_stall),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    // Blink state machine and result register
    lbdc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (w_item_valid),
        .i_item         (w_item),
        .i_cfg          (w_cfg),
        .i_out_stall    (i_out_stall),
        .o_advance      (w_advance),
        .o_out_valid    (o_out_valid),
        .o_drive_active (o_drive_active),
        .o_duty_ticks   (o_duty_ticks),
        .o_idle_level   (o_idle_level),
        .o_mode_now     (o_mode_now)
    );

endmodule

@@ rtl/lbdc_checker.sv @@
`timescale 1ns / 1ps
`include "led_blink_duty_controller_defines.svh"

module lbdc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic                                o_drive_active,
    input  logic [lbdc_pkg::DUTY_BITS-1:0]      o_duty_ticks,
    input  logic [1:0]                          o_mode_now
);

    // A stalled result stays offered
    `LBDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // Duty is zero whenever the PWM is stopped
    `LBDC_ASSERT_NOW(a_idle_duty, i_clk, i_rst_n, o_out_valid && !o_drive_active, o_duty_ticks == '0)

    // Mode code is never the unused value
    `LBDC_ASSERT_NOW(a_mode_code, i_clk, i_rst_n, o_out_valid, o_mode_now != 2'd3)

    // Off mode never drives the LED
    `LBDC_ASSERT_NOW(a_off_dark, i_clk, i_rst_n, o_out_valid && o_mode_now == lbdc_pkg::MODE_OFF, !o_drive_active)

endmodule

bind led_blink_duty_controller lbdc_checker u_checker (.*);

@@ bench/led_drive_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the LED controller, keeps its own copy of the
// mode, blink and duty state, and compares every output transaction.
module led_drive_checker
    import lbdc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [1:0]                i_req_type,
    input  logic [IV_FIELD_BITS-1:0]  i_blink_interval_ms,
    input  logic [CNT_BITS-1:0]       i_blink_count,
    input  logic                      i_blink_forever,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_drive_active,
    input  logic [DUTY_BITS-1:0]      i_duty_ticks,
    input  logic                      i_idle_level,
    input  logic [1:0]                i_mode_now,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic                 drive;
        logic [DUTY_BITS-1:0] duty;
        logic                 idle;
        t_mode                mode;
    } t_led_out;

    // Mirrored configuration
    logic [PCT_BITS-1:0]      pct_set;
    logic                     low_set;

    // Mirrored blink state
    t_mode                    mode_q;
    logic                     lit_q;
    logic [INTERVAL_BITS-1:0] half_period;
    logic [CNT_BITS-1:0]      blinks_left;
    logic                     endless;
    logic [INTERVAL_BITS-1:0] ms_count;

    t_led_out                 led_expect_q[$];
    int                       miss_count = 0;
    int                       pending_n = 0;

    assign o_fail_count = miss_count;
    assign o_pending    = pending_n;

    // Lit compare value: max * percent / 100, flipped for a low-active LED
    function automatic logic [DUTY_BITS-1:0] lit_compare();
        int unsigned d;
        d = (32'(DUTY_MAX) * 32'(pct_set)) / 100;
        if (low_set) begin
            d = 32'(DUTY_MAX) - d;
        end
        return d[DUTY_BITS-1:0];
    endfunction

    // Toggle point: an exhausted finite count drops to off, else flip the level
    task automatic toggle_step();
        if (!endless && blinks_left == '0) begin
            mode_q = MODE_OFF;
        end else begin
            lit_q = ~lit_q;
            if (!lit_q && !endless && blinks_left != '0) begin
                blinks_left = blinks_left - CNT_BITS'(1);
            end
        end
    endtask

    // Advance the mirrored state by one request and form the expected output
    task automatic apply_request(input t_item it, output t_led_out res);
        logic [INTERVAL_BITS-1:0] iv;
        iv = it.interval[INTERVAL_BITS-1:0];
        case (it.req)
            REQ_TICK: begin
                if (mode_q == MODE_BLINK) begin
                    ms_count = ms_count + INTERVAL_BITS'(1);
                    if (ms_count >= half_period) begin
                        ms_count = '0;
                        toggle_step();
                    end
                end
            end
            REQ_OFF: mode_q = MODE_OFF;
            REQ_ON:  mode_q = MODE_ON;
            default: begin
                half_period = (iv == '0) ? INTERVAL_BITS'(1) : iv;
                blinks_left = it.count;
                endless     = it.unlimited;
                if (mode_q != MODE_BLINK) begin
                    lit_q = 1'b0;
                end
                mode_q   = MODE_BLINK;
                ms_count = '0;
                toggle_step();
            end
        endcase
        res.drive = (mode_q == MODE_ON) || (mode_q == MODE_BLINK && lit_q);
        res.duty  = res.drive ? lit_compare() : '0;
        res.idle  = low_set;
        res.mode  = mode_q;
    endtask

    always @(posedge i_clk) begin : watch
        t_item    it;
        t_led_out exp_r;
        logic     bad;
        if (!i_rst_n) begin
            pct_set     = PCT_MAX;
            low_set     = 1'b0;
            mode_q      = MODE_OFF;
            lit_q       = 1'b0;
            half_period = INTERVAL_BITS'(1);
            blinks_left = '0;
            endless     = 1'b0;
            ms_count    = '0;
            led_expect_q.delete();
        end else begin
            // Register writes land before any transaction of the same edge
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ON_DUTY_PERCENT: pct_set = (i_cfg_data > PCT_MAX) ? PCT_MAX : i_cfg_data;
                    CFG_LOW_ACTIVE:      low_set = i_cfg_data[0];
                    default: ;
                endcase
            end

            // Output transaction against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (led_expect_q.size() == 0) begin
                    miss_count++;
                    if (miss_count <= 10) begin
                        $display("%0t: unexpected output drive %0b duty %0d idle %0b mode %0d",
                                 $time, i_drive_active, i_duty_ticks, i_idle_level, i_mode_now);
                    end
                end else begin
                    exp_r = led_expect_q.pop_front();
                    bad = (i_drive_active !== exp_r.drive) || (i_duty_ticks !== exp_r.duty) ||
                          (i_idle_level !== exp_r.idle) || (i_mode_now !== 2'(exp_r.mode));
                    if (bad) begin
                        miss_count++;
                        if (miss_count <= 10) begin
                            $display("%0t: mismatch exp drive %0b duty %0d idle %0b mode %0d",
                                     $time, exp_r.drive, exp_r.duty, exp_r.idle, exp_r.mode);
                            $display("%0t:          got drive %0b duty %0d idle %0b mode %0d",
                                     $time, i_drive_active, i_duty_ticks, i_idle_level,
                                     i_mode_now);
                        end
                    end
                end
            end

            // Input transaction: predict and queue its result
            if (i_in_valid && !i_in_stall) begin
                it.req       = t_req'(i_req_type);
                it.interval  = i_blink_interval_ms;
                it.count     = i_blink_count;
                it.unlimited = i_blink_forever;
                apply_request(it, exp_r);
                led_expect_q.push_back(exp_r);
            end
        end
        pending_n = led_expect_q.size();
    end

endmodule

@@ bench/tb_led_blink_duty_controller.sv @@
`timescale 1ns / 1ps

module tb_led_blink_duty_controller;
    import lbdc_pkg::*;

    localparam int TOTAL_ITEMS  = 900;
    localparam int PHASE_ITEMS  = 220;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    // Indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [1:0]                req_type  = '0;
    logic [IV_FIELD_BITS-1:0]  interval  = '0;
    logic [CNT_BITS-1:0]       count     = '0;
    logic                      forever_f = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      drive_active;
    logic [DUTY_BITS-1:0]      duty_ticks;
    logic                      idle_level;
    logic [1:0]                mode_now;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_idx   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    led_blink_duty_controller DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_req_type          (req_type),
        .i_blink_interval_ms (interval),
        .i_blink_count       (count),
        .i_blink_forever     (forever_f),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_drive_active      (drive_active),
        .o_duty_ticks        (duty_ticks),
        .o_idle_level        (idle_level),
        .o_mode_now          (mode_now),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data)
    );

    led_drive_checker u_led_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_req_type          (req_type),
        .i_blink_interval_ms (interval),
        .i_blink_count       (count),
        .i_blink_forever     (forever_f),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_drive_active      (drive_active),
        .i_duty_ticks        (duty_ticks),
        .i_idle_level        (idle_level),
        .i_mode_now          (mode_now),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // 8 ns clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("led_blink_duty_controller verification failed");
        $finish;
    end

    // One input transaction; entered and left at a falling edge
    task automatic send_item(input t_req req, input logic [15:0] iv, input logic [15:0] cnt,
                             input logic fe);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        interval  <= iv;
        count     <= cnt;
        forever_f <= fe;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering and wait for every outstanding result, plus pipeline slack
    task automatic settle();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    // Mostly short half periods so the ticks reach toggle points
    function automatic logic [15:0] pick_interval();
        int r;
        r = $urandom_range(9);
        if (r < 6) return 16'($urandom_range(1, 4));
        if (r == 6) return 16'd0;
        if (r == 7) return 16'($urandom_range(5, 20));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_count();
        if ($urandom_range(9) < 7) return 16'($urandom_range(0, 4));
        return 16'($urandom);
    endfunction

    task automatic tick_run(input int n);
        repeat (n) send_item(REQ_TICK, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    endtask

    // A blink command followed by ticks, occasionally re-armed mid-run; else noise
    task automatic random_sequence();
        int kind;
        kind = $urandom_range(9);
        if (kind <= 6) begin
            send_item(REQ_BLINK, pick_interval(), pick_count(), ($urandom_range(3) == 0));
            tick_run($urandom_range(0, 24));
            if (kind == 6) begin
                send_item(REQ_BLINK, pick_interval(), pick_count(), ($urandom_range(3) == 0));
                tick_run($urandom_range(0, 16));
            end
        end else if (kind == 7) begin
            send_item($urandom_range(1) ? REQ_ON : REQ_OFF, 16'($urandom), 16'($urandom),
                      1'($urandom_range(1)));
        end else if (kind == 8) begin
            tick_run($urandom_range(1, 3));
        end else begin
            send_item(t_req'($urandom_range(3)), 16'($urandom), 16'($urandom),
                      1'($urandom_range(1)));
        end
    endtask

    initial begin
        int  target;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle requests, repeats, count exhaustion, zero and full-scale fields
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);  // tick while off
        send_item(REQ_OFF,   16'd0,      16'd0,      1'b0);  // off while off
        send_item(REQ_ON,    16'hFFFF,   16'hFFFF,   1'b1);
        send_item(REQ_ON,    16'd0,      16'd0,      1'b0);  // on while on
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);  // tick while on
        send_item(REQ_OFF,   16'd0,      16'd0,      1'b0);
        send_item(REQ_BLINK, 16'd5,      16'd0,      1'b0);  // finite zero count: straight off
        send_item(REQ_BLINK, 16'd0,      16'd1,      1'b0);  // zero interval read as one
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);  // count spent: back to off
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);
        send_item(REQ_BLINK, 16'hFFFF,   16'hFFFF,   1'b1);
        send_item(REQ_TICK,  16'hFFFF,   16'hFFFF,   1'b1);
        send_item(REQ_BLINK, 16'd1,      16'd2,      1'b0);  // re-arm while blinking keeps level
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);
        send_item(REQ_BLINK, 16'd2,      16'd0,      1'b1);  // endless with zero count
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);
        send_item(REQ_TICK,  16'd0,      16'd0,      1'b0);
        send_item(REQ_ON,    16'd0,      16'd0,      1'b0);
        send_item(REQ_BLINK, 16'd3,      16'd3,      1'b0);  // from on: level starts unlit
        send_item(REQ_OFF,   16'd0,      16'd0,      1'b0);
        settle();

        // Random phases, each under its own idling pattern and register setting
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                    write_reg(CFG_ON_DUTY_PERCENT, 7'd0);
                    write_reg(CFG_LOW_ACTIVE, 7'd1);
                end
                1: begin
                    idle_pct = 48; stall_pct = 0;
                    write_reg(CFG_ON_DUTY_PERCENT, 7'd127);
                    write_reg(CFG_LOW_ACTIVE, 7'h7E);
                end
                2: begin
                    idle_pct = 0;  stall_pct = 48;
                    write_reg(CFG_ON_DUTY_PERCENT, 7'($urandom_range(1, 99)));
                    write_reg(CFG_LOW_ACTIVE, 7'h01);
                    write_reg(CFG_SPARE_A, 7'($urandom));
                    write_reg(CFG_SPARE_B, 7'($urandom));
                end
                default: begin
                    idle_pct = 16; stall_pct = 16;
                    write_reg(CFG_ON_DUTY_PERCENT, 7'($urandom_range(0, 127)));
                    write_reg(CFG_LOW_ACTIVE, 7'($urandom));
                end
            endcase
            target = (phase == 3) ? TOTAL_ITEMS : items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                // Long receiver hold-off while the sender keeps going
                if (phase == 0 && !hold_done && items_sent > target - 120) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                // Sender pause until the output side has drained
                if (phase == 2 && !pause_done && items_sent > target - 110) begin
                    settle();
                    pause_done = 1'b1;
                end
                random_sequence();
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("led_blink_duty_controller verification clean");
        end else begin
            $display("led_blink_duty_controller verification failed");
        end
        $finish;
    end

endmodule
